/* hdl/vprq_pkg.sv */
package vprq_pkg;

    localparam int FRACTION_BITS_DEF = 14;
    localparam int DATA_W = 16;
    localparam int CMAG_W = 34;
    localparam int NMAG_W = 30;
    localparam int ROOT_IN_W = 64;
    localparam int Q_DEPTH = 4;
    localparam int THRESH_SHIFT = 24;
    localparam logic [15:0] THRESH_RESET = 16'd17;

    typedef struct packed {
        logic signed [DATA_W-1:0] v_z;
        logic signed [DATA_W-1:0] v_y;
        logic signed [DATA_W-1:0] v_x;
        logic signed [DATA_W-1:0] u_z;
        logic signed [DATA_W-1:0] u_y;
        logic signed [DATA_W-1:0] u_x;
    } vec_pair_t;

    typedef struct packed {
        logic                     zero;
        logic signed [33:0]       dt;
        logic signed [32:0]       cx;
        logic signed [32:0]       cy;
        logic signed [32:0]       cz;
        logic signed [DATA_W-1:0] ux;
        logic signed [DATA_W-1:0] uy;
        logic signed [DATA_W-1:0] uz;
        logic                     ux_gt;
    } root_pay_t;

    typedef struct packed {
        logic [3:0][CMAG_W-1:0] mag;
        logic [3:0]             neg;
        logic                   opp;
        logic                   zero;
    } cls_item_t;

    typedef struct packed {
        logic [3:0][NMAG_W-1:0] mk;
        logic [3:0]             neg;
        logic                   opp;
        logic                   zero;
        logic                   szero;
    } norm_pay_t;

endpackage

/* hdl/vector_pair_rotation_quaternion.sv */
// rotation quaternion between two vectors, signed Q1.FRACTION_BITS fixed point
// s_* channel: one item per vector pair, s_tdata = u_x, u_y, u_z, v_x, v_y, v_z
// m_* channel: one result item per input, m_tdata = quat_w, quat_x, quat_y, quat_z,
//   m_tuser = opposite_flag, zero_flag
// cfg_* channel: write of the opposite threshold, always ready, change it only while idle
// throughput: one item per cycle when not stalled; every unit is fully pipelined
// pipeline, in order from accept to result:
//   front: products, sums, norm product, 32-stage norm square root, classify
//   queue: 4 entries between front and back
//   back: shift, squares, sum, 32-stage square root, divider setup,
//   one divider stage per quotient bit, output register
// a stalled receiver holds the back pipeline; the front keeps taking items until the
// queue fills, then s_tready drops
// reset clears all valid state and loads the threshold with 17; no clearing pass
module vector_pair_rotation_quaternion
    import vprq_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // u_x, u_y, u_z, v_x, v_y, v_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // quat_w, quat_x, quat_y, quat_z
    output logic [1:0]  m_tuser,    // opposite_flag, zero_flag
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0] thresh_reg;
    logic        q_full, q_push, q_pop, q_nonempty;
    cls_item_t   q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_valid)
        begin
            thresh_reg <= cfg_data;
        end
    end

    vprq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (vec_pair_t'(s_tdata)),
        .threshold (thresh_reg),
        .q_full    (q_full),
        .push      (q_push),
        .item      (q_wdata)
    );

    vprq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .rdata    (q_rdata),
        .nonempty (q_nonempty)
    );

    vprq_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_nonempty),
        .pop       (q_pop),
        .item      (q_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

/* hdl/vprq_isqrt.sv */
module vprq_isqrt #(
    parameter int W  = 64,
    parameter int PW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [W-1:0]    x_in,
    input  logic [PW-1:0]   pay_in,
    output logic            out_valid,
    output logic [W/2-1:0]  root,
    output logic [PW-1:0]   pay_out
);

    localparam int NS = W / 2;

    logic [W-1:0]  x_reg   [NS];
    logic [W-1:0]  res_reg [NS];
    logic [PW-1:0] pay_reg [NS];
    logic [NS-1:0] vld_reg;

    logic [W-1:0]  x_cur   [NS];
    logic [W-1:0]  res_cur [NS];
    logic [PW-1:0] pay_cur [NS];
    logic [NS-1:0] vld_cur;

    genvar g;
    for (g = 0; g < NS; g++)
    begin : g_stage
        logic [W-1:0] one_c;
        logic [W-1:0] trial_c;

        if (g == 0)
        begin : g_first
            assign x_cur[g]   = x_in;
            assign res_cur[g] = '0;
            assign pay_cur[g] = pay_in;
            assign vld_cur[g] = in_valid;
        end
        else
        begin : g_next
            assign x_cur[g]   = x_reg[g-1];
            assign res_cur[g] = res_reg[g-1];
            assign pay_cur[g] = pay_reg[g-1];
            assign vld_cur[g] = vld_reg[g-1];
        end

        assign one_c   = W'(1) << (W - 2 - 2 * g);
        assign trial_c = res_cur[g] + one_c;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= vld_cur[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pay_reg[g] <= pay_cur[g];
                if (x_cur[g] >= trial_c)
                begin
                    x_reg[g]   <= x_cur[g] - trial_c;
                    res_reg[g] <= (res_cur[g] >> 1) + one_c;
                end
                else
                begin
                    x_reg[g]   <= x_cur[g];
                    res_reg[g] <= res_cur[g] >> 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign root      = res_reg[NS-1][W/2-1:0];
    assign pay_out   = pay_reg[NS-1];

endmodule

/* hdl/vprq_front.sv */
module vprq_front
    import vprq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  vec_pair_t   in_data,
    input  logic [15:0] threshold,
    input  logic        q_full,
    output logic        push,
    output cls_item_t   item
);

    function automatic logic [16:0] abs16(input logic signed [15:0] a);
        logic signed [16:0] e;
        e = 17'(a);
        return (e < 0) ? 17'(-e) : 17'(e);
    endfunction

    function automatic logic [CMAG_W-1:0] abs35(input logic signed [34:0] a);
        return (a < 0) ? CMAG_W'(-a) : CMAG_W'(a);
    endfunction

    logic adv;

    // products
    logic               p1_vld_reg;
    logic signed [31:0] squ_reg [3];
    logic signed [31:0] sqv_reg [3];
    logic signed [31:0] dotp_reg [3];
    logic signed [31:0] crs_reg [6];
    logic signed [15:0] ux1_reg, uy1_reg, uz1_reg;
    logic               gt1_reg;

    // sums
    logic               p2_vld_reg;
    logic [31:0]        du_reg, dv_reg;
    root_pay_t          pay2_reg;

    // norm product
    logic               p3_vld_reg;
    logic [63:0]        prod_reg;
    root_pay_t          pay3_reg;

    logic               rt_vld;
    logic [31:0]        rt_n;
    root_pay_t          rt_pay;

    logic               c1_vld_reg;
    logic [CMAG_W-1:0]  ru_reg;
    logic [47:0]        tn_reg;
    root_pay_t          pay_c1_reg;

    logic               c2_vld_reg;
    cls_item_t          item_reg;

    logic signed [34:0] r_c;
    logic [CMAG_W-1:0]  ru_c;
    logic [47:0]        tn_c;
    logic               opp_c;
    logic signed [34:0] sc_c [4];
    cls_item_t          item_c;

    assign adv      = !q_full || !c2_vld_reg;
    assign in_ready = adv;
    assign push     = c2_vld_reg && !q_full;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg <= in_valid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            c1_vld_reg <= rt_vld;
            c2_vld_reg <= c1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            squ_reg[0]  <= in_data.u_x * in_data.u_x;
            squ_reg[1]  <= in_data.u_y * in_data.u_y;
            squ_reg[2]  <= in_data.u_z * in_data.u_z;
            sqv_reg[0]  <= in_data.v_x * in_data.v_x;
            sqv_reg[1]  <= in_data.v_y * in_data.v_y;
            sqv_reg[2]  <= in_data.v_z * in_data.v_z;
            dotp_reg[0] <= in_data.u_x * in_data.v_x;
            dotp_reg[1] <= in_data.u_y * in_data.v_y;
            dotp_reg[2] <= in_data.u_z * in_data.v_z;
            crs_reg[0]  <= in_data.u_y * in_data.v_z;
            crs_reg[1]  <= in_data.u_z * in_data.v_y;
            crs_reg[2]  <= in_data.u_z * in_data.v_x;
            crs_reg[3]  <= in_data.u_x * in_data.v_z;
            crs_reg[4]  <= in_data.u_x * in_data.v_y;
            crs_reg[5]  <= in_data.u_y * in_data.v_x;
            ux1_reg     <= in_data.u_x;
            uy1_reg     <= in_data.u_y;
            uz1_reg     <= in_data.u_z;
            gt1_reg     <= abs16(in_data.u_x) > abs16(in_data.u_z);

            du_reg <= $unsigned(squ_reg[0]) + $unsigned(squ_reg[1]) + $unsigned(squ_reg[2]);
            dv_reg <= $unsigned(sqv_reg[0]) + $unsigned(sqv_reg[1]) + $unsigned(sqv_reg[2]);
            pay2_reg.zero  <= ((squ_reg[0] | squ_reg[1] | squ_reg[2]) == '0) ||
                              ((sqv_reg[0] | sqv_reg[1] | sqv_reg[2]) == '0);
            pay2_reg.dt    <= 34'(dotp_reg[0]) + 34'(dotp_reg[1]) + 34'(dotp_reg[2]);
            pay2_reg.cx    <= 33'(crs_reg[0]) - 33'(crs_reg[1]);
            pay2_reg.cy    <= 33'(crs_reg[2]) - 33'(crs_reg[3]);
            pay2_reg.cz    <= 33'(crs_reg[4]) - 33'(crs_reg[5]);
            pay2_reg.ux    <= ux1_reg;
            pay2_reg.uy    <= uy1_reg;
            pay2_reg.uz    <= uz1_reg;
            pay2_reg.ux_gt <= gt1_reg;

            prod_reg      <= 64'(du_reg) * 64'(dv_reg);
            pay3_reg      <= pay2_reg;

            ru_reg     <= ru_c;
            tn_reg     <= tn_c;
            pay_c1_reg <= rt_pay;

            item_reg <= item_c;
        end
    end

    vprq_isqrt #(
        .W  (ROOT_IN_W),
        .PW ($bits(root_pay_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p3_vld_reg),
        .x_in      (prod_reg),
        .pay_in    (pay3_reg),
        .out_valid (rt_vld),
        .root      (rt_n),
        .pay_out   (rt_pay)
    );

    assign r_c  = $signed({3'b000, rt_n}) + 35'(rt_pay.dt);
    assign ru_c = (r_c < 0) ? '0 : r_c[CMAG_W-1:0];
    assign tn_c = threshold * rt_n;

    always_comb
    begin
        opp_c = {ru_reg, THRESH_SHIFT'(0)} < (CMAG_W + THRESH_SHIFT)'(tn_reg);
        if (opp_c)
        begin
            sc_c[0] = '0;
            if (pay_c1_reg.ux_gt)
            begin
                sc_c[1] = -35'(pay_c1_reg.uy);
                sc_c[2] = 35'(pay_c1_reg.ux);
                sc_c[3] = '0;
            end
            else
            begin
                sc_c[1] = '0;
                sc_c[2] = -35'(pay_c1_reg.uz);
                sc_c[3] = 35'(pay_c1_reg.uy);
            end
        end
        else
        begin
            sc_c[0] = $signed({1'b0, ru_reg});
            sc_c[1] = 35'(pay_c1_reg.cx);
            sc_c[2] = 35'(pay_c1_reg.cy);
            sc_c[3] = 35'(pay_c1_reg.cz);
        end
        for (int i = 0; i < 4; i++)
        begin
            item_c.mag[i] = abs35(sc_c[i]);
            item_c.neg[i] = sc_c[i] < 0;
        end
        item_c.opp  = opp_c;
        item_c.zero = pay_c1_reg.zero;
    end

endmodule

/* hdl/vprq_queue.sv */
module vprq_queue
    import vprq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cls_item_t wdata,
    output logic      full,
    input  logic      pop,
    output cls_item_t rdata,
    output logic      nonempty
);

    localparam int AW = $clog2(Q_DEPTH);

    cls_item_t     mem_reg [Q_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full     = count_reg == (AW + 1)'(Q_DEPTH);
    assign nonempty = count_reg != '0;
    assign rdata    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("item pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
        else $error("item popped from empty queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

/* hdl/vprq_back.sv */
module vprq_back
    import vprq_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        pop,
    input  cls_item_t   item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_data,
    output logic [1:0]  out_user
);

    localparam int NW  = FRACTION_BITS + NMAG_W + 1;
    localparam int QS  = FRACTION_BITS + 1;
    localparam int QW  = FRACTION_BITS + 1;
    localparam int LIM = (FRACTION_BITS >= 15) ? 32767 : (1 << FRACTION_BITS);

    logic en;

    logic                   b1_vld_reg;
    logic [3:0][NMAG_W-1:0] mk1_reg;
    logic [3:0]             neg1_reg;
    logic                   opp1_reg, zero1_reg;

    logic                   b2_vld_reg;
    logic [59:0]            sq_reg [4];
    logic [3:0][NMAG_W-1:0] mk2_reg;
    logic [3:0]             neg2_reg;
    logic                   opp2_reg, zero2_reg;

    logic                   b3_vld_reg;
    logic [61:0]            s_reg;
    norm_pay_t              pay3_reg;

    logic                   rt_vld;
    logic [31:0]            rt_d;
    norm_pay_t              rt_pay;

    logic                   pr_vld_reg;
    logic [NW-1:0]          num_reg [4];
    logic [31:0]            dv_reg;
    norm_pay_t              pay_pr_reg;

    logic [CMAG_W-1:0]      or_c;
    logic [2:0]             k_c;

    logic [31:0]            rem_reg  [QS][4];
    logic [QW-1:0]          quo_reg  [QS][4];
    logic [NW-1:0]          numd_reg [QS][4];
    logic [31:0]            dd_reg   [QS];
    norm_pay_t              payd_reg [QS];
    logic [QS-1:0]          vldd_reg;

    logic [31:0]            rem_cur  [QS][4];
    logic [QW-1:0]          quo_cur  [QS][4];
    logic [NW-1:0]          numd_cur [QS][4];
    logic [31:0]            dd_cur   [QS];
    norm_pay_t              payd_cur [QS];
    logic [QS-1:0]          vldd_cur;

    logic                   out_vld_reg;
    logic [63:0]            out_data_reg;
    logic [1:0]             out_user_reg;
    logic [63:0]            data_c;
    logic [14:0]            qs_c [4];

    assign en        = !out_vld_reg || out_ready;
    assign pop       = en && q_valid;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    // common shift that brings every magnitude below 2^30
    always_comb
    begin
        or_c = item.mag[0] | item.mag[1] | item.mag[2] | item.mag[3];
        if (or_c[CMAG_W-1])
        begin
            k_c = 3'd4;
        end
        else if (or_c[CMAG_W-2])
        begin
            k_c = 3'd3;
        end
        else if (or_c[CMAG_W-3])
        begin
            k_c = 3'd2;
        end
        else if (or_c[CMAG_W-4])
        begin
            k_c = 3'd1;
        end
        else
        begin
            k_c = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            b3_vld_reg  <= 1'b0;
            pr_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_vld_reg  <= q_valid;
            b2_vld_reg  <= b1_vld_reg;
            b3_vld_reg  <= b2_vld_reg;
            pr_vld_reg  <= rt_vld;
            out_vld_reg <= vldd_reg[QS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mk1_reg[i] <= NMAG_W'(item.mag[i] >> k_c);
                sq_reg[i]  <= 60'(mk1_reg[i]) * 60'(mk1_reg[i]);
                num_reg[i] <= (NW'(rt_pay.mk[i]) << FRACTION_BITS) + NW'(rt_d >> 1);
            end
            neg1_reg  <= item.neg;
            opp1_reg  <= item.opp;
            zero1_reg <= item.zero;

            mk2_reg   <= mk1_reg;
            neg2_reg  <= neg1_reg;
            opp2_reg  <= opp1_reg;
            zero2_reg <= zero1_reg;

            s_reg <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]) + 62'(sq_reg[3]);
            pay3_reg.mk    <= mk2_reg;
            pay3_reg.neg   <= neg2_reg;
            pay3_reg.opp   <= opp2_reg;
            pay3_reg.zero  <= zero2_reg;
            pay3_reg.szero <= (sq_reg[0] | sq_reg[1] | sq_reg[2] | sq_reg[3]) == '0;

            dv_reg     <= rt_d;
            pay_pr_reg <= rt_pay;

            out_data_reg <= data_c;
            if (payd_reg[QS-1].zero)
            begin
                out_user_reg <= 2'b10;
            end
            else if (payd_reg[QS-1].szero)
            begin
                out_user_reg <= 2'b00;
            end
            else
            begin
                out_user_reg <= {1'b0, payd_reg[QS-1].opp};
            end
        end
    end

    vprq_isqrt #(
        .W  (ROOT_IN_W),
        .PW ($bits(norm_pay_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b3_vld_reg),
        .x_in      ({2'b00, s_reg}),
        .pay_in    (pay3_reg),
        .out_valid (rt_vld),
        .root      (rt_d),
        .pay_out   (rt_pay)
    );

    // restoring divider, one quotient bit per stage, four lanes
    genvar g, l;
    for (g = 0; g < QS; g++)
    begin : g_div
        if (g == 0)
        begin : g_first
            for (l = 0; l < 4; l++)
            begin : g_lane
                assign rem_cur[g][l]  = 32'(num_reg[l][NW-1:FRACTION_BITS+1]);
                assign quo_cur[g][l]  = '0;
                assign numd_cur[g][l] = num_reg[l];
            end
            assign dd_cur[g]   = dv_reg;
            assign payd_cur[g] = pay_pr_reg;
            assign vldd_cur[g] = pr_vld_reg;
        end
        else
        begin : g_next
            for (l = 0; l < 4; l++)
            begin : g_lane
                assign rem_cur[g][l]  = rem_reg[g-1][l];
                assign quo_cur[g][l]  = quo_reg[g-1][l];
                assign numd_cur[g][l] = numd_reg[g-1][l];
            end
            assign dd_cur[g]   = dd_reg[g-1];
            assign payd_cur[g] = payd_reg[g-1];
            assign vldd_cur[g] = vldd_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vldd_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vldd_reg[g] <= vldd_cur[g];
            end
        end

        for (l = 0; l < 4; l++)
        begin : g_step
            logic [32:0] t_c;
            assign t_c = {rem_cur[g][l], numd_cur[g][l][FRACTION_BITS-g]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    numd_reg[g][l] <= numd_cur[g][l];
                    if (t_c >= {1'b0, dd_cur[g]})
                    begin
                        rem_reg[g][l] <= 32'(t_c - {1'b0, dd_cur[g]});
                        quo_reg[g][l] <= {quo_cur[g][l][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[g][l] <= 32'(t_c);
                        quo_reg[g][l] <= {quo_cur[g][l][QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dd_reg[g]   <= dd_cur[g];
                payd_reg[g] <= payd_cur[g];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (quo_reg[QS-1][i] > QW'(LIM))
            begin
                qs_c[i] = 15'(LIM);
            end
            else
            begin
                qs_c[i] = 15'(quo_reg[QS-1][i]);
            end
            if (payd_reg[QS-1].zero || payd_reg[QS-1].szero)
            begin
                data_c[16*i +: 16] = '0;
            end
            else if (payd_reg[QS-1].neg[i])
            begin
                data_c[16*i +: 16] = -{1'b0, qs_c[i]};
            end
            else
            begin
                data_c[16*i +: 16] = {1'b0, qs_c[i]};
            end
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import vprq_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;
    localparam int LAT = 76 + FB;
    localparam int N_RANDOM = 1530;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        opp;
        logic        zero;
    } quat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    logic [15:0] threshold;
    vec_pair_t   pending_pairs[$];
    quat_t       expected_quats[$];
    int          errors;
    int          send_idle;
    int          recv_idle;
    bit          quiet;
    bit          cfg_req;
    logic [15:0] cfg_value;

    vector_pair_rotation_quaternion DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned isqrt(longint unsigned a);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > a)
            b >>= 2;
        while (b != 0)
        begin
            if (a >= res + b)
            begin
                a -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned absval(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    function automatic quat_t rotation_between(vec_pair_t p, logic [15:0] thr);
        longint ux, uy, uz, vx, vy, vz, dt, r;
        longint unsigned du, dv, n, ru, s, d, q, one;
        longint c[4];
        longint unsigned m[4];
        int k;
        bit ok;
        quat_t res;
        res = '0;
        ux = p.u_x; uy = p.u_y; uz = p.u_z;
        vx = p.v_x; vy = p.v_y; vz = p.v_z;
        du = ux * ux + uy * uy + uz * uz;
        dv = vx * vx + vy * vy + vz * vz;
        if (du == 0 || dv == 0)
        begin
            res.zero = 1'b1;
            return res;
        end
        n = isqrt(du * dv);
        dt = ux * vx + uy * vy + uz * vz;
        r = longint'(n) + dt;
        ru = r < 0 ? 0 : r;
        if ((ru << 24) < longint'(thr) * n)
        begin
            res.opp = 1'b1;
            c[0] = 0;
            if (absval(ux) > absval(uz))
            begin
                c[1] = -uy; c[2] = ux; c[3] = 0;
            end
            else
            begin
                c[1] = 0; c[2] = -uz; c[3] = uy;
            end
        end
        else
        begin
            c[0] = ru;
            c[1] = uy * vz - uz * vy;
            c[2] = uz * vx - ux * vz;
            c[3] = ux * vy - uy * vx;
        end
        for (int i = 0; i < 4; i++)
            m[i] = absval(c[i]);
        k = 0;
        do
        begin
            ok = 1;
            for (int i = 0; i < 4; i++)
                if ((m[i] >> k) >= (64'd1 << 30))
                    ok = 0;
            if (!ok)
                k++;
        end while (!ok);
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] >>= k;
            s += m[i] * m[i];
        end
        if (s == 0)
        begin
            res.opp = 1'b0;
            return res;
        end
        d = isqrt(s);
        one = 64'd1 << FB;
        for (int i = 0; i < 4; i++)
        begin
            q = (m[i] * one + d / 2) / d;
            if (q > one)
                q = one;
            if (q > 32767)
                q = 32767;
            q = c[i] < 0 ? -q : q;
            case (i)
                0: res.w = q[15:0];
                1: res.x = q[15:0];
                2: res.y = q[15:0];
                default: res.z = q[15:0];
            endcase
        end
        return res;
    endfunction

    function automatic logic [15:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'($urandom_range(0, 2) == 0 ? -16384 : ($urandom_range(0, 1) ? 16384 : 0));
        if (sel == 1)
            return 16'($urandom_range(0, 65535));
        if (sel == 2)
            return 16'($signed($urandom_range(0, 64)) - 32);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic vec_pair_t rand_pair();
        vec_pair_t p;
        int sel;
        int sc;
        p.u_x = rand_comp(); p.u_y = rand_comp(); p.u_z = rand_comp();
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            // near opposite or parallel
            sc = $urandom_range(0, 1) ? -1 : 1;
            p.v_x = 16'(sc * p.u_x + $signed($urandom_range(0, 2)) - 1);
            p.v_y = 16'(sc * p.u_y + $signed($urandom_range(0, 2)) - 1);
            p.v_z = 16'(sc * p.u_z + $signed($urandom_range(0, 2)) - 1);
        end
        else if (sel == 3)
        begin
            p.v_x = 16'(-p.u_x); p.v_y = 16'(-p.u_y); p.v_z = 16'(-p.u_z);
        end
        else
        begin
            p.v_x = rand_comp(); p.v_y = rand_comp(); p.v_z = rand_comp();
        end
        if ($urandom_range(0, 40) == 0)
        begin
            p.u_x = 0; p.u_y = 0; p.u_z = 0;
        end
        return p;
    endfunction

    function automatic vec_pair_t mk(int ax, int ay, int az, int bx, int by, int bz);
        vec_pair_t p;
        p.u_x = 16'(ax); p.u_y = 16'(ay); p.u_z = 16'(az);
        p.v_x = 16'(bx); p.v_y = 16'(by); p.v_z = 16'(bz);
        return p;
    endfunction

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || expected_quats.size() != 0)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] val);
        cfg_value = val;
        cfg_req = 1;
        @(posedge clk);
        while (cfg_req)
            @(posedge clk);
        threshold = val;
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            pending_pairs.push_back(rand_pair());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_data <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_valid <= 1'b0;
            cfg_req <= 0;
        end
        else if (cfg_req)
        begin
            cfg_valid <= 1'b1;
            cfg_data <= cfg_value;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_idle <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_quats.push_back(rotation_between(pending_pairs.pop_front(),
                                                          threshold));
            end
            if (s_tvalid && !s_tready)
                ;
            else if (send_idle > 0)
            begin
                send_idle <= send_idle - 1;
                s_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 29) == 0)
            begin
                send_idle <= $urandom_range(1, 18);
                s_tvalid <= 1'b0;
            end
            else if (pending_pairs.size() > (s_tvalid && s_tready ? 0 : 0) &&
                     !(s_tvalid && s_tready && pending_pairs.size() == 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_pairs[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        quat_t got;
        quat_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_idle <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                       m_tuser[0], m_tuser[1]};
                if (expected_quats.size() == 0)
                begin
                    $error("unexpected item %h", got);
                    errors++;
                end
                else
                begin
                    want = expected_quats.pop_front();
                    if (got.w !== want.w)
                        begin $error("quat_w exp %0d got %0d", $signed(want.w), $signed(got.w)); errors++; end
                    if (got.x !== want.x)
                        begin $error("quat_x exp %0d got %0d", $signed(want.x), $signed(got.x)); errors++; end
                    if (got.y !== want.y)
                        begin $error("quat_y exp %0d got %0d", $signed(want.y), $signed(got.y)); errors++; end
                    if (got.z !== want.z)
                        begin $error("quat_z exp %0d got %0d", $signed(want.z), $signed(got.z)); errors++; end
                    if (got.opp !== want.opp)
                        begin $error("opposite_flag exp %0d got %0d", want.opp, got.opp); errors++; end
                    if (got.zero !== want.zero)
                        begin $error("zero_flag exp %0d got %0d", want.zero, got.zero); errors++; end
                end
            end
            if (recv_idle > 0)
            begin
                recv_idle <= recv_idle - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 24) == 0)
            begin
                recv_idle <= $urandom_range(1, 18);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #50000000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        errors = 0;
        quiet = 0;
        cfg_req = 0;
        threshold = THRESH_RESET;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero vectors, parallel, opposite, both axis choices
        pending_pairs.push_back(mk(16384, 0, 0, 0, 16384, 0));
        pending_pairs.push_back(mk(0, 0, 0, 100, 2, 3));
        pending_pairs.push_back(mk(5, 6, 7, 0, 0, 0));
        pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(mk(16384, 16384, 16384, 16384, 16384, 16384));
        pending_pairs.push_back(mk(-16384, -16384, -16384, -16384, -16384, -16384));
        pending_pairs.push_back(mk(16384, 100, 5, -16384, -100, -5));
        pending_pairs.push_back(mk(5, 100, 16384, -5, -100, -16384));
        pending_pairs.push_back(mk(300, 7, 300, -300, -7, -300));
        pending_pairs.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767));
        pending_pairs.push_back(mk(-32768, 32767, -32768, -32768, 32767, -32768));
        pending_pairs.push_back(mk(1, 0, 0, -1, 0, 0));
        pending_pairs.push_back(mk(1, 0, 0, 0, 0, 1));
        pending_pairs.push_back(mk(16384, 0, 0, -16384, 1, 0));
        pending_pairs.push_back(mk(-1, -1, -1, 1, 1, 1));
        pending_pairs.push_back(mk(12345, -4321, 999, -999, 4321, -12345));
        wait_idle();

        write_threshold(16'd0);
        pending_pairs.push_back(mk(16384, 100, 5, -16384, -100, -5));
        pending_pairs.push_back(mk(1, 0, 0, -1, 0, 0));
        push_random(400);
        wait_idle();
        write_threshold(16'hFFFF);
        push_random(400);
        wait_idle();
        write_threshold(16'($urandom_range(0, 65535)));
        push_random(400);
        wait_idle();
        write_threshold(16'd17);
        push_random(200);
        while (pending_pairs.size() != 0)
            @(posedge clk);
        quiet = 1;
        push_random(130);
        wait_idle();

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
